// ----- design/imconv_pkg.sv -----
// Shared types, sizes and arithmetic helpers for the streaming 2-D convolution.
// No dependencies; every other design file imports this package.
package imconv_pkg;

   localparam int KMAX       = 3;
   localparam int WIN        = 3;
   localparam int TAPS       = WIN * WIN;
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int LANES      = 3;
   localparam int LINE_ROWS  = KMAX + 1;
   localparam int BANK_W     = $clog2(LINE_ROWS);
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int DIM_W      = 11;
   localparam int SAMP_W     = 16;
   localparam int PIX_W      = LANES * SAMP_W;
   localparam int PROD_W     = 2 * SAMP_W;
   localparam int LSUM_W     = PROD_W + 4;
   localparam int MSUM_W     = LSUM_W + 2;
   localparam int RES_W      = 24;
   localparam int CIDX_W     = 4;
   localparam int CSR_IDX_W  = 3;

   typedef enum logic [1:0] {
      OP_PIXEL = 2'd0,
      OP_FLUSH = 2'd1,
      OP_COEF  = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   localparam logic [CSR_IDX_W-1:0] REG_WIDTH    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KSIZE    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PRESERVE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CHANNELS = 3'd4;

   typedef logic signed [SAMP_W-1:0] samp_type;
   typedef logic signed [LSUM_W-1:0] lsum_type;
   typedef logic signed [RES_W-1:0]  res_type;

   typedef struct packed {
      logic                         ec0;
      logic [WIN-1:0][BANK_W-1:0]   bsel;
      logic [TAPS-1:0]              tap_en;
      logic [LANES-1:0]             lane_en;
      logic                         preserve;
      logic [COL_W-1:0]             col;
      logic [ROW_W-1:0]             row;
      logic                         last;
   } emit_meta_type;

   function automatic res_type round_sat(input logic signed [MSUM_W-1:0] acc);
      logic signed [MSUM_W-1:0]    t;
      logic signed [MSUM_W-13:0]   q;
      t = acc + MSUM_W'(2048);
      q = t[MSUM_W-1:12];
      if (q > (MSUM_W-12)'(8388607)) return res_type'(24'h7FFFFF);
      else if (q < -(MSUM_W-12)'(8388608)) return res_type'(24'h800000);
      else return q[RES_W-1:0];
   endfunction

endpackage

// ----- design/imconv_ctl.sv -----
// Front control: registers, kernel coefficients, raster counters, emit decision.
// Depends on imconv_pkg.
module imconv_ctl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   input  logic [imconv_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [imconv_pkg::DIM_W-1:0]      csr_data,
   input  logic                              accept,
   input  logic [1:0]                        op,
   input  logic [imconv_pkg::CIDX_W-1:0]     coef_index,
   input  imconv_pkg::samp_type              coef_value,
   output logic                              wr_en,
   output logic [imconv_pkg::BANK_W-1:0]     wr_bank,
   output logic [imconv_pkg::COL_W-1:0]      wr_col,
   output logic [imconv_pkg::COL_W-1:0]      rd_col_a,
   output logic [imconv_pkg::COL_W-1:0]      rd_col_b,
   output logic                              emit,
   output imconv_pkg::emit_meta_type         meta,
   output imconv_pkg::samp_type              coef_sel [imconv_pkg::TAPS]
);
   import imconv_pkg::*;

   logic [DIM_W-1:0] width_ff, height_ff;
   logic [1:0]       ksize_ff, chans_ff;
   logic             preserve_ff;
   samp_type         coef_ff [TAPS];
   logic [COL_W-1:0] in_col_ff, in_col_in, emit_col_ff, emit_col_in;
   logic [ROW_W-1:0] in_row_ff, in_row_in, emit_row_ff, emit_row_in;
   logic             frame_in_ff, frame_in_in;

   logic [DIM_W-1:0] w_eff, h_eff, w_m1_full, h_m1_full;
   logic [COL_W-1:0] wm1, nx;
   logic [ROW_W-1:0] hm1, ny, row_m1, row_p1;
   logic [COL_W-1:0] ic_n;
   logic [ROW_W-1:0] ir_n;
   logic             fi_n, look, tick, last, restart;
   logic [1:0]       nch;
   int               jj, ii, ks, p, idx;

   always_comb begin
      w_eff = (width_ff == '0) ? DIM_W'(1) :
              (width_ff > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_ff;
      h_eff = (height_ff == '0) ? DIM_W'(1) :
              (height_ff > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_ff;
      w_m1_full = w_eff - DIM_W'(1);
      h_m1_full = h_eff - DIM_W'(1);
      wm1 = w_m1_full[COL_W-1:0];
      hm1 = h_m1_full[ROW_W-1:0];
      look = (ksize_ff == 2'd3);
      nch = (chans_ff == 2'd0) ? 2'd1 : chans_ff;
   end

   // pixel write and input raster advance
   always_comb begin
      wr_en = accept && (op == OP_PIXEL) && !frame_in_ff
              && (in_col_ff <= wm1) && (in_row_ff <= hm1);
      wr_bank = in_row_ff[BANK_W-1:0];
      wr_col = in_col_ff;
      ic_n = in_col_ff;
      ir_n = in_row_ff;
      fi_n = frame_in_ff;
      if (wr_en) begin
         if (in_col_ff == wm1) begin
            ic_n = '0;
            if (in_row_ff == hm1) begin
               ir_n = '0;
               fi_n = 1'b1;
            end else begin
               ir_n = in_row_ff + ROW_W'(1);
            end
         end else begin
            ic_n = in_col_ff + COL_W'(1);
         end
      end
   end

   // emit decision
   always_comb begin
      nx = (look && emit_col_ff != wm1) ? emit_col_ff + COL_W'(1) : emit_col_ff;
      ny = (look && emit_row_ff != hm1) ? emit_row_ff + ROW_W'(1) : emit_row_ff;
      tick = accept && (op == OP_PIXEL || op == OP_FLUSH);
      emit = tick && (fi_n || ny < ir_n || (ny == ir_n && nx < ic_n));
      last = (emit_col_ff == wm1) && (emit_row_ff == hm1);
      rd_col_a = emit_col_ff;
      rd_col_b = (emit_col_ff == wm1) ? emit_col_ff : emit_col_ff + COL_W'(1);
      row_m1 = (emit_row_ff == '0) ? '0 : emit_row_ff - ROW_W'(1);
      row_p1 = (emit_row_ff == hm1) ? emit_row_ff : emit_row_ff + ROW_W'(1);
   end

   always_comb begin
      ks = int'(ksize_ff);
      p = ksize_ff[1] ? 1 : 0;
      meta.ec0 = (emit_col_ff == '0);
      meta.bsel[0] = row_m1[BANK_W-1:0];
      meta.bsel[1] = emit_row_ff[BANK_W-1:0];
      meta.bsel[2] = row_p1[BANK_W-1:0];
      meta.preserve = preserve_ff;
      meta.col = emit_col_ff;
      meta.row = emit_row_ff;
      meta.last = last;
      for (int c = 0; c < LANES; c++) begin
         meta.lane_en[c] = (c < int'(nch));
      end
      for (int a = 0; a < WIN; a++) begin
         for (int b = 0; b < WIN; b++) begin
            jj = a - 1 + p;
            ii = b - 1 + p;
            meta.tap_en[a*WIN+b] = (ks != 0) && (jj >= 0) && (jj < ks)
                                   && (ii >= 0) && (ii < ks);
            idx = meta.tap_en[a*WIN+b] ? jj * ks + ii : 0;
            coef_sel[a*WIN+b] = coef_ff[idx[CIDX_W-1:0]];
         end
      end
   end

   // counter next values
   always_comb begin
      in_col_in = ic_n;
      in_row_in = ir_n;
      frame_in_in = fi_n;
      emit_col_in = emit_col_ff;
      emit_row_in = emit_row_ff;
      restart = csr_valid && (csr_index == REG_WIDTH || csr_index == REG_HEIGHT
                              || csr_index == REG_KSIZE);
      if (emit) begin
         if (last) begin
            in_col_in = '0;
            in_row_in = '0;
            frame_in_in = 1'b0;
            emit_col_in = '0;
            emit_row_in = '0;
         end else if (emit_col_ff == wm1) begin
            emit_col_in = '0;
            emit_row_in = emit_row_ff + ROW_W'(1);
         end else begin
            emit_col_in = emit_col_ff + COL_W'(1);
         end
      end
      if (restart) begin
         in_col_in = '0;
         in_row_in = '0;
         frame_in_in = 1'b0;
         emit_col_in = '0;
         emit_row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= DIM_W'(1024);
         height_ff <= DIM_W'(1024);
         ksize_ff <= 2'd3;
         preserve_ff <= 1'b1;
         chans_ff <= 2'd3;
         in_col_ff <= '0;
         in_row_ff <= '0;
         emit_col_ff <= '0;
         emit_row_ff <= '0;
         frame_in_ff <= 1'b0;
         for (int t = 0; t < TAPS; t++) coef_ff[t] <= '0;
      end else begin
         in_col_ff <= in_col_in;
         in_row_ff <= in_row_in;
         emit_col_ff <= emit_col_in;
         emit_row_ff <= emit_row_in;
         frame_in_ff <= frame_in_in;
         if (csr_valid) begin
            case (csr_index)
               REG_WIDTH:    width_ff <= csr_data;
               REG_HEIGHT:   height_ff <= csr_data;
               REG_KSIZE:    ksize_ff <= csr_data[1:0];
               REG_PRESERVE: preserve_ff <= csr_data[0];
               REG_CHANNELS: chans_ff <= csr_data[1:0];
               default: ;
            endcase
         end
         if (accept && op == OP_COEF && coef_index < CIDX_W'(TAPS)) begin
            coef_ff[coef_index] <= coef_value;
         end
      end
   end

endmodule

// ----- design/imconv_lstore.sv -----
// Line store: one bank per buffered row, one write and two column reads a cycle.
// Depends on imconv_pkg.
module imconv_lstore (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [imconv_pkg::BANK_W-1:0]  wr_bank,
   input  logic [imconv_pkg::COL_W-1:0]   wr_col,
   input  logic [imconv_pkg::PIX_W-1:0]   wr_data,
   input  logic                           rd_en,
   input  logic [imconv_pkg::COL_W-1:0]   rd_col_a,
   input  logic [imconv_pkg::COL_W-1:0]   rd_col_b,
   output logic [imconv_pkg::PIX_W-1:0]   rd_a [imconv_pkg::LINE_ROWS],
   output logic [imconv_pkg::PIX_W-1:0]   rd_b [imconv_pkg::LINE_ROWS]
);
   import imconv_pkg::*;

   logic [PIX_W-1:0] mem_ff [LINE_ROWS][MAX_WIDTH];
   logic [PIX_W-1:0] rd_a_ff [LINE_ROWS];
   logic [PIX_W-1:0] rd_b_ff [LINE_ROWS];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_bank][wr_col] <= wr_data;
   end

   // forward a same-cycle write to the reading item
   always_ff @(posedge clock) begin
      if (rd_en) begin
         for (int b = 0; b < LINE_ROWS; b++) begin
            rd_a_ff[b] <= (wr_en && wr_bank == BANK_W'(b) && wr_col == rd_col_a)
                          ? wr_data : mem_ff[b][rd_col_a];
            rd_b_ff[b] <= (wr_en && wr_bank == BANK_W'(b) && wr_col == rd_col_b)
                          ? wr_data : mem_ff[b][rd_col_b];
         end
      end
   end

   assign rd_a = rd_a_ff;
   assign rd_b = rd_b_ff;

endmodule

// ----- design/imconv_lane.sv -----
// One channel lane: registered tap products, then a registered window sum.
// Depends on imconv_pkg.
module imconv_lane (
   input  logic                  clock,
   input  logic                  prod_ld,
   input  logic                  sum_ld,
   input  imconv_pkg::samp_type  sample [imconv_pkg::TAPS],
   input  imconv_pkg::samp_type  coef [imconv_pkg::TAPS],
   output imconv_pkg::lsum_type  sum
);
   import imconv_pkg::*;

   logic signed [PROD_W-1:0] prod_ff [TAPS];
   lsum_type                 sum_ff, sum_in;

   always_comb begin
      sum_in = '0;
      for (int t = 0; t < TAPS; t++) sum_in = sum_in + LSUM_W'(prod_ff[t]);
   end

   always_ff @(posedge clock) begin
      if (prod_ld) begin
         for (int t = 0; t < TAPS; t++) prod_ff[t] <= sample[t] * coef[t];
      end
      if (sum_ld) sum_ff <= sum_in;
   end

   assign sum = sum_ff;

endmodule

// ----- design/imconv_merge.sv -----
// Merge stage: per-lane or summed results, rounded and saturated to Q11.12.
// Depends on imconv_pkg.
module imconv_merge (
   input  logic                  clock,
   input  logic                  ld,
   input  logic                  preserve,
   input  imconv_pkg::lsum_type  sums [imconv_pkg::LANES],
   output imconv_pkg::res_type   res [imconv_pkg::LANES]
);
   import imconv_pkg::*;

   res_type                  res_ff [LANES];
   res_type                  res_in [LANES];
   logic signed [MSUM_W-1:0] total;

   always_comb begin
      total = '0;
      for (int c = 0; c < LANES; c++) total = total + MSUM_W'(sums[c]);
      for (int c = 0; c < LANES; c++) begin
         if (preserve) res_in[c] = round_sat(MSUM_W'(sums[c]));
         else if (c == 0) res_in[c] = round_sat(total);
         else res_in[c] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (ld) begin
         for (int c = 0; c < LANES; c++) res_ff[c] <= res_in[c];
      end
   end

   assign res = res_ff;

endmodule

// ----- design/image_convolution_2d_top.sv -----
// Streaming 2-D convolution with clamped borders, top level and stage valids.
// Depends on imconv_pkg, imconv_ctl, imconv_lstore, imconv_lane, imconv_merge.
//
//   port group   dir   handshake             contents
//   req_*        in    req_valid/req_ready   op, three samples, coefficient write
//   rsp_*        out   rsp_valid/rsp_ready   three results, position, frame end
//   csr_*        in    csr_valid/csr_ready   register index and data
//
// One item per clock unless rsp_ready holds the pipeline; a result passes the s1, product, sum and merge registers.
// Throughput is set by the line store: each bank gives two column reads a cycle.
// Four pipeline stages each hold one item and advance whenever the next is free.
// Synchronous active-high reset sets registers to defaults and clears counters, coefficients and valids.
module image_convolution_2d_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_op,
   input  logic signed [15:0]                req_chan0,
   input  logic signed [15:0]                req_chan1,
   input  logic signed [15:0]                req_chan2,
   input  logic [3:0]                        req_coef_index,
   input  logic signed [15:0]                req_coef_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [23:0]                rsp_res0,
   output logic signed [23:0]                rsp_res1,
   output logic signed [23:0]                rsp_res2,
   output logic [9:0]                        rsp_out_col,
   output logic [9:0]                        rsp_out_row,
   output logic                              rsp_frame_end,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [imconv_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [imconv_pkg::DIM_W-1:0]      csr_data
);
   import imconv_pkg::*;

   logic             accept, emit, wr_en;
   logic [BANK_W-1:0] wr_bank;
   logic [COL_W-1:0] wr_col, rd_col_a, rd_col_b;
   emit_meta_type    meta, s1_meta_ff, s2_meta_ff, s3_meta_ff;
   samp_type         coef_sel [TAPS];
   samp_type         s1_coef_ff [TAPS];
   logic [PIX_W-1:0] rd_a [LINE_ROWS];
   logic [PIX_W-1:0] rd_b [LINE_ROWS];
   logic             s1_v_ff, s2_v_ff, s3_v_ff, rsp_v_ff;
   logic             s1_ready, s2_ready, s3_ready, out_ready;
   samp_type         saved_ff [WIN][LANES];
   samp_type         a_val [WIN][LANES];
   samp_type         b_val [WIN][LANES];
   samp_type         win [LANES][TAPS];
   samp_type         raw;
   lsum_type         sums [LANES];
   res_type          res [LANES];
   logic [COL_W-1:0] col_ff;
   logic [ROW_W-1:0] row_ff;
   logic             last_ff;

   assign out_ready = !rsp_v_ff || rsp_ready;
   assign s3_ready = !s3_v_ff || out_ready;
   assign s2_ready = !s2_v_ff || s3_ready;
   assign s1_ready = !s1_v_ff || s2_ready;
   assign req_ready = s1_ready;
   assign accept = req_valid && s1_ready;
   assign csr_ready = 1'b1;

   imconv_ctl u_ctl (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .accept     (accept),
      .op         (req_op),
      .coef_index (req_coef_index),
      .coef_value (req_coef_value),
      .wr_en      (wr_en),
      .wr_bank    (wr_bank),
      .wr_col     (wr_col),
      .rd_col_a   (rd_col_a),
      .rd_col_b   (rd_col_b),
      .emit       (emit),
      .meta       (meta),
      .coef_sel   (coef_sel)
   );

   imconv_lstore u_lstore (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_bank  (wr_bank),
      .wr_col   (wr_col),
      .wr_data  ({req_chan2, req_chan1, req_chan0}),
      .rd_en    (accept),
      .rd_col_a (rd_col_a),
      .rd_col_b (rd_col_b),
      .rd_a     (rd_a),
      .rd_b     (rd_b)
   );

   // assemble the 3x3 window per lane; left column comes from the previous item, or from the centre at column 0
   always_comb begin
      for (int r = 0; r < WIN; r++) begin
         for (int c = 0; c < LANES; c++) begin
            a_val[r][c] = rd_a[s1_meta_ff.bsel[r]][c*SAMP_W +: SAMP_W];
            b_val[r][c] = rd_b[s1_meta_ff.bsel[r]][c*SAMP_W +: SAMP_W];
         end
      end
      for (int c = 0; c < LANES; c++) begin
         for (int t = 0; t < TAPS; t++) begin
            case (t % WIN)
               0: raw = s1_meta_ff.ec0 ? a_val[t/WIN][c] : saved_ff[t/WIN][c];
               1: raw = a_val[t/WIN][c];
               default: raw = b_val[t/WIN][c];
            endcase
            win[c][t] = (s1_meta_ff.tap_en[t] && s1_meta_ff.lane_en[c]) ? raw : '0;
         end
      end
   end

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      imconv_lane u_lane (
         .clock   (clock),
         .prod_ld (s2_ready),
         .sum_ld  (s3_ready),
         .sample  (win[g]),
         .coef    (s1_coef_ff),
         .sum     (sums[g])
      );
   end

   imconv_merge u_merge (
      .clock    (clock),
      .ld       (out_ready),
      .preserve (s3_meta_ff.preserve),
      .sums     (sums),
      .res      (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_v_ff <= accept && emit;
         if (s2_ready) s2_v_ff <= s1_v_ff;
         if (s3_ready) s3_v_ff <= s2_v_ff;
         if (out_ready) rsp_v_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_meta_ff <= meta;
         for (int t = 0; t < TAPS; t++) s1_coef_ff[t] <= coef_sel[t];
      end
      if (s2_ready) begin
         s2_meta_ff <= s1_meta_ff;
         if (s1_v_ff) begin
            for (int r = 0; r < WIN; r++) begin
               for (int c = 0; c < LANES; c++) saved_ff[r][c] <= a_val[r][c];
            end
         end
      end
      if (s3_ready) s3_meta_ff <= s2_meta_ff;
      if (out_ready) begin
         col_ff <= s3_meta_ff.col;
         row_ff <= s3_meta_ff.row;
         last_ff <= s3_meta_ff.last;
      end
   end

   assign rsp_valid = rsp_v_ff;
   assign rsp_res0 = res[0];
   assign rsp_res1 = res[1];
   assign rsp_res2 = res[2];
   assign rsp_out_col = col_ff;
   assign rsp_out_row = row_ff;
   assign rsp_frame_end = last_ff;

endmodule
